/* rtl/tcsie_pkg.sv */
// shared constants, record codes, controller commands and status for the
// two-color simplex interface extractor; no dependencies
package tcsie_pkg;

    localparam int NUM_POINTS   = 65536;
    localparam int MAX_VERTICES = 4096;
    localparam int COORD_BITS   = 24;
    localparam int COLOR_BITS   = 8;

    localparam int IDX_W   = 16;
    localparam int CNT_W   = 3;
    localparam int KIND_W  = 3;
    localparam int VIDO_W  = 12;
    localparam int ID_W    = 16;
    localparam int DIST_W  = 26;

    localparam int PIDX_BITS  = $clog2(NUM_POINTS);
    localparam int VID_BITS   = $clog2(MAX_VERTICES);
    localparam int VCNT_BITS  = VID_BITS + 1;
    localparam int KEY_BITS   = 2 * PIDX_BITS;
    localparam int PT_BITS    = 3 * COORD_BITS + COLOR_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SUM_BITS   = 2 * DIFF_BITS + 2;
    localparam int ROOT_STEPS = SUM_BITS / 2;
    localparam int STEP_BITS  = $clog2(ROOT_STEPS);

    typedef enum logic [KIND_W-1:0] {
        REC_VERTEX  = 3'd0,
        REC_EDGE    = 3'd1,
        REC_TRI     = 3'd2,
        REC_QUAD    = 3'd3,
        REC_NOT_TWO = 3'd4,
        REC_FULL    = 3'd5
    } t_rec;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CAPT,
        OP_CRD,
        OP_CGET,
        OP_PINIT,
        OP_KEY,
        OP_SRD,
        OP_SCMP,
        OP_NEW,
        OP_NEWP,
        OP_NEWQ,
        OP_DIFF,
        OP_MUL,
        OP_SQRT,
        OP_VREC,
        OP_NEXT,
        OP_FINAL,
        OP_ERR,
        OP_FULL
    } t_op;

    typedef struct packed {
        logic two_colors;
        logic ci_last;
        logic search_end;
        logic match;
        logic full;
        logic pair_last;
        logic mul_last;
        logic root_last;
        logic nc_ge2;
    } t_stat;

endpackage

/* rtl/tcsie_ram.sv */
// generic single-port ram with registered read data
// no dependencies
module tcsie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/tcsie_ctrl.sv */
// sequencing state machine: load, color reads, pair walk, table search,
// new-vertex arithmetic and record hand-off; uses tcsie_pkg
module tcsie_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_kind,
    input  logic             i_stall,
    input  tcsie_pkg::t_stat i_stat,
    output tcsie_pkg::t_op   o_op,
    output logic             o_stall,
    output logic             o_valid
);
    import tcsie_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CRD, S_CGET, S_PINIT, S_KEY, S_SRD, S_SCMP, S_NEW, S_NEWP,
        S_NEWQ, S_DIFF, S_MUL, S_SQRT, S_VREC, S_EMIT_V, S_NEXT, S_FINAL,
        S_ERR, S_FULL, S_EMIT_L
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, r_valid;
    t_op    w_op;
    logic   w_accept;

    assign w_accept = i_valid && !r_stall;

    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_op = i_kind ? OP_CAPT : OP_LOAD;
                    if (i_kind) n_state = S_CRD;
                end
            end
            S_CRD: begin
                w_op = OP_CRD;
                n_state = S_CGET;
            end
            S_CGET: begin
                w_op = OP_CGET;
                n_state = i_stat.ci_last ? S_PINIT : S_CRD;
            end
            S_PINIT: begin
                w_op = OP_PINIT;
                n_state = i_stat.two_colors ? S_KEY : S_ERR;
            end
            S_KEY: begin
                w_op = OP_KEY;
                n_state = S_SRD;
            end
            S_SRD: begin
                w_op = OP_SRD;
                if (i_stat.search_end) n_state = i_stat.full ? S_FULL : S_NEW;
                else n_state = S_SCMP;
            end
            S_SCMP: begin
                w_op = OP_SCMP;
                n_state = i_stat.match ? S_NEXT : S_SRD;
            end
            S_NEW: begin
                w_op = OP_NEW;
                n_state = S_NEWP;
            end
            S_NEWP: begin
                w_op = OP_NEWP;
                n_state = S_NEWQ;
            end
            S_NEWQ: begin
                w_op = OP_NEWQ;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                w_op = OP_DIFF;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_op = OP_MUL;
                if (i_stat.mul_last) n_state = S_SQRT;
            end
            S_SQRT: begin
                w_op = OP_SQRT;
                if (i_stat.root_last) n_state = S_VREC;
            end
            S_VREC: begin
                w_op = OP_VREC;
                n_state = S_EMIT_V;
            end
            S_EMIT_V: begin
                if (!i_stall) n_state = S_NEXT;
            end
            S_NEXT: begin
                w_op = OP_NEXT;
                n_state = i_stat.pair_last ? S_FINAL : S_KEY;
            end
            S_FINAL: begin
                w_op = OP_FINAL;
                n_state = i_stat.nc_ge2 ? S_EMIT_L : S_IDLE;
            end
            S_ERR: begin
                w_op = OP_ERR;
                n_state = S_EMIT_L;
            end
            S_FULL: begin
                w_op = OP_FULL;
                n_state = S_EMIT_L;
            end
            S_EMIT_L: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
            r_valid <= (n_state == S_EMIT_V) || (n_state == S_EMIT_L);
        end
    end

    assign o_op    = w_op;
    assign o_stall = r_stall;
    assign o_valid = r_valid;

`ifndef SYNTH
    // a pending record always blocks new input
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_valid |-> r_stall)
        else $error("record pending while input open");
    // an accepted record returns to idle or moves on to the next pair
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_L && !i_stall) |=> (r_state == S_IDLE))
        else $error("final record not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_V && !i_stall) |=> (r_state == S_NEXT))
        else $error("vertex record not followed by pair advance");
`endif
endmodule

/* rtl/tcsie_dp.sv */
// datapath: point and pair memories, color split, pair search, midpoint,
// squared distance and bit-serial root, record registers; uses tcsie_pkg, tcsie_ram
module tcsie_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tcsie_pkg::t_op                       i_op,
    input  logic [tcsie_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [tcsie_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [tcsie_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic signed [tcsie_pkg::COORD_BITS-1:0] i_coord_z,
    input  logic [tcsie_pkg::COLOR_BITS-1:0]     i_color,
    input  logic [tcsie_pkg::IDX_W-1:0]          i_vert_a,
    input  logic [tcsie_pkg::IDX_W-1:0]          i_vert_b,
    input  logic [tcsie_pkg::IDX_W-1:0]          i_vert_c,
    input  logic [tcsie_pkg::IDX_W-1:0]          i_vert_d,
    input  logic [tcsie_pkg::CNT_W-1:0]          i_vert_count,
    output tcsie_pkg::t_stat                     o_stat,
    output logic [tcsie_pkg::KIND_W-1:0]         o_record_kind,
    output logic [tcsie_pkg::VIDO_W-1:0]         o_vertex_id,
    output logic [tcsie_pkg::ID_W-1:0]           o_id_first,
    output logic [tcsie_pkg::ID_W-1:0]           o_id_second,
    output logic [tcsie_pkg::ID_W-1:0]           o_id_third,
    output logic [tcsie_pkg::ID_W-1:0]           o_id_fourth,
    output logic signed [tcsie_pkg::COORD_BITS-1:0] o_mid_x,
    output logic signed [tcsie_pkg::COORD_BITS-1:0] o_mid_y,
    output logic signed [tcsie_pkg::COORD_BITS-1:0] o_mid_z,
    output logic [tcsie_pkg::DIST_W-1:0]         o_distance,
    output logic                                 o_last
);
    import tcsie_pkg::*;

    function automatic logic [1:0] nth_set(input logic [3:0] m, input logic [1:0] n);
        logic [2:0] c;
        logic [1:0] r;
        c = 3'd0;
        r = 2'd0;
        for (int b = 0; b < 4; b++) begin
            if (m[b]) begin
                if (c == {1'b0, n}) r = 2'(b);
                c = c + 3'd1;
            end
        end
        return r;
    endfunction

    // simplex state
    logic [PIDX_BITS-1:0]  r_vidx [4];
    logic [COLOR_BITS-1:0] r_vcol [4];
    logic [CNT_W-1:0]      r_cnt;
    logic [1:0]            r_ci;
    logic [1:0]            r_i, r_j;
    logic [2:0]            r_nc;
    logic [VID_BITS-1:0]   r_ids [4];
    logic [KEY_BITS-1:0]   r_key;
    logic [VCNT_BITS-1:0]  r_k;
    logic [VCNT_BITS-1:0]  r_vcount;
    // new-vertex arithmetic
    logic [PT_BITS-1:0]    r_pc, r_qc;
    logic [DIFF_BITS-1:0]  r_dx, r_dy, r_dz;
    logic [COORD_BITS-1:0] r_mx, r_my, r_mz;
    logic [1:0]            r_axis;
    logic [SUM_BITS-1:0]   r_rem, r_root, r_bit;
    logic [STEP_BITS-1:0]  r_step;
    // record
    t_rec                  r_kind;
    logic [VIDO_W-1:0]     r_vid;
    logic [ID_W-1:0]       r_id1, r_id2, r_id3, r_id4;
    logic [COORD_BITS-1:0] r_ox, r_oy, r_oz;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_last;

    // memories
    logic                  w_pt_we, w_tab_we;
    logic [PIDX_BITS-1:0]  w_pt_addr;
    logic [VID_BITS-1:0]   w_tab_addr;
    logic [PT_BITS-1:0]    w_pt_rdata;
    logic [KEY_BITS-1:0]   w_tab_rdata;

    // color split
    logic [3:0]            w_valid, w_p0, w_rest, w_amask, w_bmask;
    logic [COLOR_BITS-1:0] w_cmin, w_c2;
    logic                  w_rest_same, w_two;
    logic [2:0]            w_s0, w_s1, w_sa, w_sb;
    logic [PIDX_BITS-1:0]  w_p, w_q, w_lo, w_hi;
    logic                  w_pair_last;

    logic [DIFF_BITS-1:0]   w_sel;
    logic [2*DIFF_BITS-1:0] w_prod;
    logic [SUM_BITS-1:0]    w_trial;
    logic [VID_BITS-1:0]    w_e0, w_e1, w_e2, w_t;
    logic [DIFF_BITS-1:0]   w_d [3];
    logic [DIFF_BITS-1:0]   w_s [3];
    t_stat                  w_stat;

    always_comb begin
        w_cmin = '1;
        w_c2   = '0;
        for (int i = 0; i < 4; i++) begin
            w_valid[i] = (r_cnt > CNT_W'(i));
            if (w_valid[i] && r_vcol[i] < w_cmin) w_cmin = r_vcol[i];
        end
        for (int i = 0; i < 4; i++) begin
            w_p0[i]   = w_valid[i] && (r_vcol[i] == w_cmin);
            w_rest[i] = w_valid[i] && (r_vcol[i] != w_cmin);
        end
        for (int i = 3; i >= 0; i--) begin
            if (w_rest[i]) w_c2 = r_vcol[i];
        end
        w_rest_same = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (w_rest[i] && r_vcol[i] != w_c2) w_rest_same = 1'b0;
        end
        w_two   = (w_rest != 4'd0) && w_rest_same;
        w_s0    = 3'($countones(w_p0));
        w_s1    = 3'($countones(w_rest));
        // larger part leads, lower color on a tie
        w_amask = (w_s1 > w_s0) ? w_rest : w_p0;
        w_bmask = (w_s1 > w_s0) ? w_p0 : w_rest;
        w_sa    = (w_s1 > w_s0) ? w_s1 : w_s0;
        w_sb    = (w_s1 > w_s0) ? w_s0 : w_s1;
    end

    assign w_p  = r_vidx[nth_set(w_amask, r_i)];
    assign w_q  = r_vidx[nth_set(w_bmask, r_j)];
    assign w_lo = (w_p < w_q) ? w_p : w_q;
    assign w_hi = (w_p < w_q) ? w_q : w_p;
    assign w_pair_last = ({1'b0, r_j} == w_sb - 3'd1) && ({1'b0, r_i} == w_sa - 3'd1);

    assign w_pt_we  = (i_op == OP_LOAD);
    assign w_tab_we = (i_op == OP_NEW);
    always_comb begin
        case (i_op)
            OP_LOAD: w_pt_addr = i_point_index[PIDX_BITS-1:0];
            OP_CRD:  w_pt_addr = r_vidx[r_ci];
            OP_NEWP: w_pt_addr = w_q;
            default: w_pt_addr = w_p;
        endcase
    end
    assign w_tab_addr = (i_op == OP_NEW) ? r_vcount[VID_BITS-1:0] : r_k[VID_BITS-1:0];

    tcsie_ram #(.WIDTH(PT_BITS), .DEPTH(NUM_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_addr  (w_pt_addr),
        .i_wdata ({i_color, i_coord_z, i_coord_y, i_coord_x}),
        .o_rdata (w_pt_rdata)
    );

    tcsie_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_VERTICES)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_addr  (w_tab_addr),
        .i_wdata (r_key),
        .o_rdata (w_tab_rdata)
    );

    // per-axis difference magnitude and sum for the midpoint
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_d[a] = DIFF_BITS'($signed(r_pc[a*COORD_BITS +: COORD_BITS]))
                   - DIFF_BITS'($signed(r_qc[a*COORD_BITS +: COORD_BITS]));
            w_s[a] = DIFF_BITS'($signed(r_pc[a*COORD_BITS +: COORD_BITS]))
                   + DIFF_BITS'($signed(r_qc[a*COORD_BITS +: COORD_BITS]));
            if (w_d[a][DIFF_BITS-1]) w_d[a] = -w_d[a];
        end
    end

    always_comb begin
        case (r_axis)
            2'd0:    w_sel = r_dx;
            2'd1:    w_sel = r_dy;
            default: w_sel = r_dz;
        endcase
    end
    assign w_prod  = (2*DIFF_BITS)'(w_sel) * (2*DIFF_BITS)'(w_sel);
    assign w_trial = r_root + r_bit;

    // ascending order of the first two or three ids
    always_comb begin
        w_e0 = r_ids[0];
        w_e1 = r_ids[1];
        w_e2 = r_ids[2];
        if (w_e0 > w_e1) begin w_t = w_e0; w_e0 = w_e1; w_e1 = w_t; end
        if (r_nc == 3'd3) begin
            if (w_e1 > w_e2) begin w_t = w_e1; w_e1 = w_e2; w_e2 = w_t; end
            if (w_e0 > w_e1) begin w_t = w_e0; w_e0 = w_e1; w_e1 = w_t; end
        end
        w_t = w_e2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else begin
            if (i_op == OP_VREC) r_vcount <= r_vcount + VCNT_BITS'(1);
        end
        case (i_op)
            OP_CAPT: begin
                r_vidx[0] <= i_vert_a[PIDX_BITS-1:0];
                r_vidx[1] <= i_vert_b[PIDX_BITS-1:0];
                r_vidx[2] <= i_vert_c[PIDX_BITS-1:0];
                r_vidx[3] <= i_vert_d[PIDX_BITS-1:0];
                r_cnt     <= (i_vert_count > CNT_W'(4)) ? CNT_W'(4) : i_vert_count;
                r_ci      <= 2'd0;
            end
            OP_CGET: begin
                r_vcol[r_ci] <= w_pt_rdata[PT_BITS-1 -: COLOR_BITS];
                r_ci         <= r_ci + 2'd1;
            end
            OP_PINIT: begin
                r_i  <= 2'd0;
                r_j  <= 2'd0;
                r_nc <= 3'd0;
            end
            OP_KEY: begin
                r_key <= {w_lo, w_hi};
                r_k   <= '0;
            end
            OP_SCMP: begin
                if (w_tab_rdata == r_key) begin
                    r_ids[r_nc[1:0]] <= r_k[VID_BITS-1:0];
                    r_nc             <= r_nc + 3'd1;
                end else begin
                    r_k <= r_k + VCNT_BITS'(1);
                end
            end
            OP_NEWP: r_pc <= w_pt_rdata;
            OP_NEWQ: r_qc <= w_pt_rdata;
            OP_DIFF: begin
                r_dx   <= w_d[0];
                r_dy   <= w_d[1];
                r_dz   <= w_d[2];
                // floor of half sum is the arithmetic shift
                r_mx   <= w_s[0][DIFF_BITS-1:1];
                r_my   <= w_s[1][DIFF_BITS-1:1];
                r_mz   <= w_s[2][DIFF_BITS-1:1];
                r_rem  <= '0;
                r_root <= '0;
                r_bit  <= SUM_BITS'(1) << (SUM_BITS - 2);
                r_step <= '0;
                r_axis <= 2'd0;
            end
            OP_MUL: begin
                r_rem  <= r_rem + SUM_BITS'(w_prod);
                r_axis <= r_axis + 2'd1;
            end
            OP_SQRT: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step + STEP_BITS'(1);
            end
            OP_VREC: begin
                r_kind           <= REC_VERTEX;
                r_vid            <= VIDO_W'(r_vcount[VID_BITS-1:0]);
                r_id1            <= ID_W'(r_key[KEY_BITS-1:PIDX_BITS]);
                r_id2            <= ID_W'(r_key[PIDX_BITS-1:0]);
                r_id3            <= '0;
                r_id4            <= '0;
                r_ox             <= r_mx;
                r_oy             <= r_my;
                r_oz             <= r_mz;
                r_dist           <= r_root[DIST_W-1:0];
                // a single pair means this record ends the simplex
                r_last           <= (w_sa == 3'd1) && (w_sb == 3'd1);
                r_ids[r_nc[1:0]] <= r_vcount[VID_BITS-1:0];
                r_nc             <= r_nc + 3'd1;
            end
            OP_NEXT: begin
                if ({1'b0, r_j} == w_sb - 3'd1) begin
                    r_j <= 2'd0;
                    r_i <= r_i + 2'd1;
                end else begin
                    r_j <= r_j + 2'd1;
                end
            end
            OP_FINAL: begin
                r_vid  <= '0;
                r_ox   <= '0;
                r_oy   <= '0;
                r_oz   <= '0;
                r_dist <= '0;
                r_last <= 1'b1;
                case (r_nc)
                    3'd2: begin
                        r_kind <= REC_EDGE;
                        r_id1  <= ID_W'(w_e0);
                        r_id2  <= ID_W'(w_e1);
                        r_id3  <= '0;
                        r_id4  <= '0;
                    end
                    3'd3: begin
                        r_kind <= REC_TRI;
                        r_id1  <= ID_W'(w_e0);
                        r_id2  <= ID_W'(w_e1);
                        r_id3  <= ID_W'(w_t);
                        r_id4  <= '0;
                    end
                    default: begin
                        // quad walks a0b0, a0b1, a1b1, a1b0
                        r_kind <= REC_QUAD;
                        r_id1  <= ID_W'(r_ids[0]);
                        r_id2  <= ID_W'(r_ids[1]);
                        r_id3  <= ID_W'(r_ids[3]);
                        r_id4  <= ID_W'(r_ids[2]);
                    end
                endcase
            end
            OP_ERR, OP_FULL: begin
                r_kind <= (i_op == OP_ERR) ? REC_NOT_TWO : REC_FULL;
                r_vid  <= '0;
                r_id1  <= '0;
                r_id2  <= '0;
                r_id3  <= '0;
                r_id4  <= '0;
                r_ox   <= '0;
                r_oy   <= '0;
                r_oz   <= '0;
                r_dist <= '0;
                r_last <= 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_stat.two_colors = w_two;
        w_stat.ci_last    = (r_ci == 2'd3);
        w_stat.search_end = (r_k == r_vcount);
        w_stat.match      = (w_tab_rdata == r_key);
        w_stat.full       = (r_vcount == VCNT_BITS'(MAX_VERTICES));
        w_stat.pair_last  = w_pair_last;
        w_stat.mul_last   = (r_axis == 2'd2);
        w_stat.root_last  = (r_step == STEP_BITS'(ROOT_STEPS - 1));
        w_stat.nc_ge2     = (r_nc >= 3'd2);
    end

    assign o_stat        = w_stat;
    assign o_record_kind = r_kind;
    assign o_vertex_id   = r_vid;
    assign o_id_first    = r_id1;
    assign o_id_second   = r_id2;
    assign o_id_third    = r_id3;
    assign o_id_fourth   = r_id4;
    assign o_mid_x       = r_ox;
    assign o_mid_y       = r_oy;
    assign o_mid_z       = r_oz;
    assign o_distance    = r_dist;
    assign o_last        = r_last;

`ifndef SYNTH
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount <= VCNT_BITS'(MAX_VERTICES))
        else $error("vertex count beyond table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_NEW) |-> (r_vcount < VCNT_BITS'(MAX_VERTICES)))
        else $error("pair written into full table");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_VREC) |=> (r_vcount == $past(r_vcount) + VCNT_BITS'(1)))
        else $error("vertex count not advanced by new vertex");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_SCMP || i_op == OP_VREC) |-> (r_nc < 3'd4))
        else $error("more than four pairs in one simplex");
`endif
endmodule

/* rtl/two_color_simplex_interface_extract_core.sv */
// a load transaction writes one point and leaves the input open; a simplex reads the
// colors of all four vertex slots and splits them, then per atom pair sets up the key,
// compares it with each stored vertex in the pair table and advances, and for a new
// pair stores it, reads both points, then runs midpoint, squares and bit-serial root
// flow: one simplex in flight, input stalled until it is done, each record held until
// taken; reset clears control state and the vertex count only, memories keep contents
module two_color_simplex_interface_extract_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_kind,
    input  logic [tcsie_pkg::IDX_W-1:0]             i_point_index,
    input  logic signed [tcsie_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [tcsie_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic signed [tcsie_pkg::COORD_BITS-1:0] i_coord_z,
    input  logic [tcsie_pkg::COLOR_BITS-1:0]        i_color,
    input  logic [tcsie_pkg::IDX_W-1:0]             i_vert_a,
    input  logic [tcsie_pkg::IDX_W-1:0]             i_vert_b,
    input  logic [tcsie_pkg::IDX_W-1:0]             i_vert_c,
    input  logic [tcsie_pkg::IDX_W-1:0]             i_vert_d,
    input  logic [tcsie_pkg::CNT_W-1:0]             i_vert_count,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [tcsie_pkg::KIND_W-1:0]            o_record_kind,
    output logic [tcsie_pkg::VIDO_W-1:0]            o_vertex_id,
    output logic [tcsie_pkg::ID_W-1:0]              o_id_first,
    output logic [tcsie_pkg::ID_W-1:0]              o_id_second,
    output logic [tcsie_pkg::ID_W-1:0]              o_id_third,
    output logic [tcsie_pkg::ID_W-1:0]              o_id_fourth,
    output logic signed [tcsie_pkg::COORD_BITS-1:0] o_mid_x,
    output logic signed [tcsie_pkg::COORD_BITS-1:0] o_mid_y,
    output logic signed [tcsie_pkg::COORD_BITS-1:0] o_mid_z,
    output logic [tcsie_pkg::DIST_W-1:0]            o_distance,
    output logic                                    o_last
);
    import tcsie_pkg::*;

    t_op   w_op;
    t_stat w_stat;

    tcsie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    tcsie_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_point_index (i_point_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_color       (i_color),
        .i_vert_a      (i_vert_a),
        .i_vert_b      (i_vert_b),
        .i_vert_c      (i_vert_c),
        .i_vert_d      (i_vert_d),
        .i_vert_count  (i_vert_count),
        .o_stat        (w_stat),
        .o_record_kind (o_record_kind),
        .o_vertex_id   (o_vertex_id),
        .o_id_first    (o_id_first),
        .o_id_second   (o_id_second),
        .o_id_third    (o_id_third),
        .o_id_fourth   (o_id_fourth),
        .o_mid_x       (o_mid_x),
        .o_mid_y       (o_mid_y),
        .o_mid_z       (o_mid_z),
        .o_distance    (o_distance),
        .o_last        (o_last)
    );
endmodule
